FILE: rtl/rgbf_pkg.sv
// shared types and codes for the rgb565 rectangle fill and blend core
package rgbf_pkg;

   // coordinate math width: signed 16-bit position plus unsigned 16-bit size
   localparam int CW = 18;

   localparam logic [1:0] CMD_DRAW  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_CLIPPED = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   localparam logic [1:0] CSR_TARGET_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_TARGET_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BYTE_SWAPPED  = 2'd2;

   localparam logic [8:0] TARGET_SIZE_RESET = 9'd256;
   localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_EVAL,
      ST_RUN,
      ST_DRAIN,
      ST_READ
   } state_type;

   typedef struct packed {
      logic       load;
      logic       setup;
      logic       step;
      logic       pix_write;
      logic       pix_read;
      logic       finish;
      logic       use_rdata;
      logic [1:0] status;
   } dp_ctrl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       empty;
      logic       out_of_range;
      logic       last;
      logic       pipe_busy;
   } dp_stat_type;

endpackage

FILE: rtl/rgb565_rect_fill_blend_core.sv
// top level of the rgb565 rectangle fill and blend core
// The core holds a MAX_WIDTH x MAX_HEIGHT frame buffer of 16-bit words in one
// memory with one write and one registered read per cycle. A command is taken
// when start is high and busy is low, and exactly one result comes back on
// rsp_valid for one cycle; the result must be captured in that cycle. A pixel
// write, an unused command or a rejected or clipped command finishes in the
// evaluate state after setup, a pixel read in the read state after that, and
// the registered result shows in the next cycle. In a draw of a visible area
// of W x H pixels the walker issues one pixel per cycle through the memory
// read, a blend stage and the write back, drained before the result. No clearing pass
// runs after reset: pixels must be written before they are blended or read.
module rgb565_rect_fill_blend_core
   import rgbf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_rect_width,
   input  logic [15:0]        req_rect_height,
   input  logic [15:0]        req_color,
   input  logic [7:0]         req_alpha,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_write_data,
   output logic               rsp_valid,
   output logic [15:0]        rsp_read_data,
   output logic [1:0]         rsp_status
);

   dp_ctrl_type ctl;
   dp_stat_type stat;

   rgbf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctl   (ctl),
      .busy  (busy)
   );

   rgbf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_color       (req_color),
      .req_alpha       (req_alpha),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status)
   );

   a_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after command transfer");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer still busy");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid)
      else $error("finished command gave no result");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_read_data == 16'd0)
      else $error("read data on a failed command");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      ctl.step && !stat.last |=> ctl.step)
      else $error("pixel walk stopped before last pixel");

endmodule

FILE: rtl/rgbf_ctrl.sv
// command sequencer for the rectangle fill and blend core
module rgbf_ctrl
   import rgbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output dp_ctrl_type ctl,
   output logic        busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (stat.cmd)
               CMD_DRAW:  state_in = stat.empty ? ST_IDLE : ST_RUN;
               CMD_READ:  state_in = stat.out_of_range ? ST_IDLE : ST_READ;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_RUN: begin
            if (stat.last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            ctl.load = start;
         end
         ST_SETUP: begin
            ctl.setup = 1'b1;
         end
         ST_EVAL: begin
            unique case (stat.cmd)
               CMD_DRAW: begin
                  if (stat.empty) begin
                     ctl.finish = 1'b1;
                     ctl.status = STATUS_CLIPPED;
                  end
               end
               CMD_WRITE: begin
                  ctl.finish = 1'b1;
                  if (stat.out_of_range) begin
                     ctl.status = STATUS_RANGE;
                  end else begin
                     ctl.pix_write = 1'b1;
                     ctl.status    = STATUS_DONE;
                  end
               end
               CMD_READ: begin
                  if (stat.out_of_range) begin
                     ctl.finish = 1'b1;
                     ctl.status = STATUS_RANGE;
                  end else begin
                     ctl.pix_read = 1'b1;
                  end
               end
               default: begin
                  ctl.finish = 1'b1;
                  ctl.status = STATUS_DONE;
               end
            endcase
         end
         ST_RUN: begin
            ctl.step = 1'b1;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               ctl.finish = 1'b1;
               ctl.status = STATUS_DONE;
            end
         end
         ST_READ: begin
            ctl.finish    = 1'b1;
            ctl.use_rdata = 1'b1;
            ctl.status    = STATUS_DONE;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule

FILE: rtl/rgbf_datapath.sv
// clip logic, pixel walker, blend pipeline and frame buffer memory
module rgbf_datapath
   import rgbf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
)
(
   input  logic               clock,
   input  logic               reset,
   input  dp_ctrl_type        ctl,
   output dp_stat_type        stat,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]        req_rect_width,
   input  logic [15:0]        req_rect_height,
   input  logic [15:0]        req_color,
   input  logic [7:0]         req_alpha,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_write_data,
   output logic               rsp_valid,
   output logic [15:0]        rsp_read_data,
   output logic [1:0]         rsp_status
);

   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

   // configuration
   logic [8:0] target_width_ff, target_height_ff;
   logic       byte_swapped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_width_ff  <= TARGET_SIZE_RESET;
         target_height_ff <= TARGET_SIZE_RESET;
         byte_swapped_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TARGET_WIDTH:  target_width_ff  <= csr_write_data;
            CSR_TARGET_HEIGHT: target_height_ff <= csr_write_data;
            CSR_BYTE_SWAPPED:  byte_swapped_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // captured command
   logic [1:0]         cmd_ff;
   logic signed [15:0] pos_x_ff, pos_y_ff;
   logic [15:0]        rect_width_ff, rect_height_ff, color_ff;
   logic [7:0]         alpha_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff         <= req_cmd;
         pos_x_ff       <= req_pos_x;
         pos_y_ff       <= req_pos_y;
         rect_width_ff  <= req_rect_width;
         rect_height_ff <= req_rect_height;
         color_ff       <= req_color;
         alpha_ff       <= req_alpha;
      end
   end

   // clipping
   logic [XW-1:0]        vis_w;
   logic [YW-1:0]        vis_h;
   logic signed [CW-1:0] vw_s, vh_s, x_s, y_s, right_s, bottom_s;
   logic                 empty_c, range_c;
   logic [XW-1:0]        x0_c, x1_c;
   logic [YW-1:0]        y0_c, y1_c;

   always_comb begin
      vis_w = (16'(target_width_ff) > 16'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(target_width_ff);
      vis_h = (16'(target_height_ff) > 16'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                                                         : YW'(target_height_ff);
      vw_s     = signed'(CW'(vis_w));
      vh_s     = signed'(CW'(vis_h));
      x_s      = CW'(pos_x_ff);
      y_s      = CW'(pos_y_ff);
      right_s  = x_s + signed'(CW'(rect_width_ff));
      bottom_s = y_s + signed'(CW'(rect_height_ff));
      empty_c  = (rect_width_ff == 16'd0) || (rect_height_ff == 16'd0) ||
                 (vis_w == '0) || (vis_h == '0) ||
                 (right_s <= 0) || (bottom_s <= 0) || (x_s >= vw_s) || (y_s >= vh_s);
      range_c  = (x_s < 0) || (y_s < 0) || (x_s >= vw_s) || (y_s >= vh_s);
      x0_c     = (x_s < 0) ? '0 : XW'(x_s);
      y0_c     = (y_s < 0) ? '0 : YW'(y_s);
      x1_c     = (right_s > vw_s) ? vis_w : XW'(right_s);
      y1_c     = (bottom_s > vh_s) ? vis_h : YW'(bottom_s);
   end

   logic          empty_ff, range_ff;
   logic [XW-1:0] x0_ff, x1_ff, px_ff, px_in, px_next;
   logic [YW-1:0] y1_ff, py_ff, py_in, py_next;

   always_ff @(posedge clock) begin
      if (ctl.setup) begin
         empty_ff <= empty_c;
         range_ff <= range_c;
         x0_ff    <= x0_c;
         x1_ff    <= x1_c;
         y1_ff    <= y1_c;
      end
      px_ff <= px_in;
      py_ff <= py_in;
   end

   // pixel walker, row by row
   always_comb begin
      px_next = px_ff + 1'b1;
      py_next = py_ff + 1'b1;
      px_in   = px_ff;
      py_in   = py_ff;
      if (ctl.setup) begin
         px_in = x0_c;
         py_in = y0_c;
      end else if (ctl.step) begin
         if (px_next == x1_ff) begin
            px_in = x0_ff;
            py_in = py_next;
         end else begin
            px_in = px_next;
         end
      end
   end

   logic [AW-1:0] run_addr, pix_addr;

   assign run_addr = AW'(py_ff) * ROW_STRIDE + AW'(px_ff);
   assign pix_addr = AW'(YW'(pos_y_ff)) * ROW_STRIDE + AW'(XW'(pos_x_ff));

   // frame buffer
   logic [15:0]   mem [DEPTH];
   logic [15:0]   rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;

   // blend pipeline
   logic          s1_valid_ff, s2_valid_ff;
   logic [AW-1:0] s1_addr_ff, s2_addr_ff;
   logic [15:0]   s2_data_ff, s2_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.step;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_addr_ff <= run_addr;
      s2_addr_ff <= s1_addr_ff;
      s2_data_ff <= s2_data_in;
   end

   logic [15:0] under, blended, fill;
   logic [8:0]  weight, inv;
   logic [14:0] r_sum, g_sum, b_sum;

   always_comb begin
      under   = byte_swapped_ff ? {rd_data_ff[7:0], rd_data_ff[15:8]} : rd_data_ff;
      weight  = {1'b0, alpha_ff} + 9'd1;
      inv     = 9'd256 - weight;
      r_sum   = 15'(under[15:11]) * 15'(inv) + 15'(color_ff[15:11]) * 15'(weight);
      g_sum   = 15'(under[10:5]) * 15'(inv) + 15'(color_ff[10:5]) * 15'(weight);
      b_sum   = 15'(under[4:0]) * 15'(inv) + 15'(color_ff[4:0]) * 15'(weight);
      blended = {r_sum[12:8], g_sum[13:8], b_sum[12:8]};
      if (byte_swapped_ff) begin
         blended = {blended[7:0], blended[15:8]};
         fill    = {color_ff[7:0], color_ff[15:8]};
      end else begin
         fill    = color_ff;
      end
      s2_data_in = (alpha_ff == ALPHA_OPAQUE) ? fill : blended;
   end

   always_comb begin
      mem_we    = ctl.pix_write | s2_valid_ff;
      mem_waddr = ctl.pix_write ? pix_addr : s2_addr_ff;
      mem_wdata = ctl.pix_write ? color_ff : s2_data_ff;
      mem_re    = ctl.step | ctl.pix_read;
      mem_raddr = ctl.pix_read ? pix_addr : run_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // status to the sequencer
   always_comb begin
      stat.cmd          = cmd_ff;
      stat.empty        = empty_ff;
      stat.out_of_range = range_ff;
      stat.last         = (px_next == x1_ff) && (py_next == y1_ff);
      stat.pipe_busy    = s1_valid_ff | s2_valid_ff;
   end

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_read_data_ff;
   logic [1:0]  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.finish;
      end
      if (ctl.finish) begin
         rsp_read_data_ff <= ctl.use_rdata ? rd_data_ff : 16'd0;
         rsp_status_ff    <= ctl.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

FILE: test/rgb565_rect_fill_blend_core_tb.sv
// self-checking testbench for the rgb565 rectangle fill and blend core
module rgb565_rect_fill_blend_core_tb;
   import rgbf_pkg::*;

   localparam int FB_W = 256;
   localparam int FB_H = 256;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        rect_width;
      logic [15:0]        rect_height;
      logic [15:0]        color;
      logic [7:0]         alpha;
   } draw_cmd_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      bit           is_csr;
      logic [1:0]   csr_idx;
      logic [8:0]   csr_data;
      draw_cmd_type op;
   } queue_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [15:0]        req_rect_width = '0;
   logic [15:0]        req_rect_height = '0;
   logic [15:0]        req_color = '0;
   logic [7:0]         req_alpha = '0;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [8:0]         csr_write_data = '0;
   logic               rsp_valid;
   logic [15:0]        rsp_read_data;
   logic [1:0]         rsp_status;

   rgb565_rect_fill_blend_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_rect_width (req_rect_width),
      .req_rect_height(req_rect_height),
      .req_color      (req_color),
      .req_alpha      (req_alpha),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // shadow copy of the frame buffer and registers
   logic [15:0] shadow_fb [0:FB_W*FB_H-1];
   logic [8:0]  shadow_width = 9'd256;
   logic [8:0]  shadow_height = 9'd256;
   logic        shadow_swap = 1'b0;

   queue_entry_type cmd_queue[$];
   rsp_type         pending_rsp[$];
   int              fail_count = 0;
   int              gen_vw = FB_W;
   int              gen_vh = FB_H;
   int              calm_left = 0;

   function automatic logic [15:0] swap16(input logic [15:0] w);
      return {w[7:0], w[15:8]};
   endfunction

   function automatic logic [15:0] mix565(input logic [15:0] under, input logic [15:0] over,
                                          input int weight);
      int inv, r, g, b;
      inv = 256 - weight;
      r = (int'(under[15:11]) * inv + int'(over[15:11]) * weight) >> 8;
      g = (int'(under[10:5]) * inv + int'(over[10:5]) * weight) >> 8;
      b = (int'(under[4:0]) * inv + int'(over[4:0]) * weight) >> 8;
      return {r[4:0], g[5:0], b[4:0]};
   endfunction

   task automatic run_command(input draw_cmd_type c, output rsp_type r);
      int vw, vh, x, y, right, bottom, x0, y0, x1, y1, idx;
      r.read_data = '0;
      r.status = STATUS_DONE;
      vw = (shadow_width > FB_W) ? FB_W : int'(shadow_width);
      vh = (shadow_height > FB_H) ? FB_H : int'(shadow_height);
      x = $signed(c.pos_x);
      y = $signed(c.pos_y);
      case (c.cmd)
         CMD_DRAW: begin
            right = x + int'(c.rect_width);
            bottom = y + int'(c.rect_height);
            x0 = (x < 0) ? 0 : x;
            y0 = (y < 0) ? 0 : y;
            x1 = (right > vw) ? vw : right;
            y1 = (bottom > vh) ? vh : bottom;
            if (c.rect_width == 0 || c.rect_height == 0 || right <= 0 || bottom <= 0 ||
                x >= vw || y >= vh || x1 <= x0 || y1 <= y0) begin
               r.status = STATUS_CLIPPED;
            end else begin
               for (int py = y0; py < y1; py++) begin
                  for (int px = x0; px < x1; px++) begin
                     idx = py * FB_W + px;
                     if (c.alpha == ALPHA_OPAQUE)
                        shadow_fb[idx] = shadow_swap ? swap16(c.color) : c.color;
                     else if (shadow_swap)
                        shadow_fb[idx] = swap16(mix565(swap16(shadow_fb[idx]), c.color,
                                                       int'(c.alpha) + 1));
                     else
                        shadow_fb[idx] = mix565(shadow_fb[idx], c.color, int'(c.alpha) + 1);
                  end
               end
            end
         end
         CMD_WRITE, CMD_READ: begin
            if (x < 0 || y < 0 || x >= vw || y >= vh) begin
               r.status = STATUS_RANGE;
            end else if (c.cmd == CMD_WRITE) begin
               shadow_fb[y * FB_W + x] = c.color;
            end else begin
               r.read_data = shadow_fb[y * FB_W + x];
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_op(input logic [1:0] op, input int x, input int y, input int w,
                           input int h, input int color, input int a);
      queue_entry_type e;
      e = '0;
      e.op.cmd = op;
      e.op.pos_x = 16'(x);
      e.op.pos_y = 16'(y);
      e.op.rect_width = 16'(w);
      e.op.rect_height = 16'(h);
      e.op.color = 16'(color);
      e.op.alpha = 8'(a);
      cmd_queue.push_back(e);
   endtask

   task automatic queue_csr(input logic [1:0] idx, input int data);
      queue_entry_type e;
      e = '0;
      e.is_csr = 1'b1;
      e.csr_idx = idx;
      e.csr_data = 9'(data);
      cmd_queue.push_back(e);
      if (idx == CSR_TARGET_WIDTH)
         gen_vw = (data > FB_W) ? FB_W : data;
      else if (idx == CSR_TARGET_HEIGHT)
         gen_vh = (data > FB_H) ? FB_H : data;
   endtask

   function automatic int pick_coord(input int vis);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60 && vis > 0)
         return $urandom_range(0, vis - 1);
      if (r < 85)
         return int'($urandom_range(0, vis + 40)) - 20;
      return $urandom_range(0, 65535);
   endfunction

   task automatic queue_random_ops(input int n);
      int sel, w, h, a;
      logic [1:0] op;
      repeat (n) begin
         sel = $urandom_range(0, 99);
         op = (sel < 50) ? CMD_DRAW : (sel < 70) ? CMD_WRITE : (sel < 95) ? CMD_READ : CMD_UNUSED;
         sel = $urandom_range(0, 99);
         if (sel < 75) begin
            w = $urandom_range(0, 24);
            h = $urandom_range(0, 24);
         end else if (sel < 85) begin
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 3);
         end else if (sel < 95) begin
            w = $urandom_range(0, 3);
            h = $urandom_range(0, 65535);
         end else begin
            w = $urandom_range(0, 96);
            h = $urandom_range(0, 96);
         end
         a = ($urandom_range(0, 99) < 35) ? ALPHA_OPAQUE : $urandom_range(0, 254);
         queue_op(op, pick_coord(gen_vw), pick_coord(gen_vh), w, h, $urandom_range(0, 65535), a);
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // driver
   queue_entry_type head;
   draw_cmd_type    issued_op;
   rsp_type         predicted;
   logic            nxt_start;
   logic            nxt_csr_en;
   bit              took;
   int              gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_write_en <= 1'b0;
         gap_left = 0;
      end else begin
         nxt_start = start;
         nxt_csr_en = 1'b0;
         took = start && !busy;
         if (took) begin
            run_command(issued_op, predicted);
            pending_rsp.push_back(predicted);
            nxt_start = 1'b0;
         end
         if (!nxt_start && cmd_queue.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               head = cmd_queue[0];
               if (head.is_csr) begin
                  // registers only change with the core idle and nothing in flight
                  if (!took && !busy && pending_rsp.size() == 0) begin
                     void'(cmd_queue.pop_front());
                     nxt_csr_en = 1'b1;
                     csr_index <= head.csr_idx;
                     csr_write_data <= head.csr_data;
                     case (head.csr_idx)
                        CSR_TARGET_WIDTH:  shadow_width = head.csr_data;
                        CSR_TARGET_HEIGHT: shadow_height = head.csr_data;
                        CSR_BYTE_SWAPPED:  shadow_swap = head.csr_data[0];
                        default: ;
                     endcase
                  end
               end else begin
                  void'(cmd_queue.pop_front());
                  issued_op = head.op;
                  req_cmd <= head.op.cmd;
                  req_pos_x <= head.op.pos_x;
                  req_pos_y <= head.op.pos_y;
                  req_rect_width <= head.op.rect_width;
                  req_rect_height <= head.op.rect_height;
                  req_color <= head.op.color;
                  req_alpha <= head.op.alpha;
                  nxt_start = 1'b1;
                  gap_left = pick_gap();
               end
            end
         end
         start <= nxt_start;
         csr_write_en <= nxt_csr_en;
      end
   end

   // monitor
   rsp_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: read_data %h status %0d", rsp_read_data, rsp_status);
            fail_count++;
         end else begin
            oldest = pending_rsp.pop_front();
            if (rsp_read_data !== oldest.read_data) begin
               $error("read_data: expected %h, got %h", oldest.read_data, rsp_read_data);
               fail_count++;
            end
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer and no result
   int stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("rgb565_rect_fill_blend_core_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      // reset target, 256 x 256 unswapped; first fill makes every pixel written
      queue_op(CMD_DRAW, 0, 0, FB_W, FB_H, 'h1234, ALPHA_OPAQUE);
      queue_op(CMD_WRITE, 0, 0, 0, 0, 'hFFFF, 0);
      queue_op(CMD_READ, 0, 0, 0, 0, 0, 0);
      queue_op(CMD_WRITE, 255, 255, 0, 0, 'h0000, 0);
      queue_op(CMD_READ, 255, 255, 0, 0, 0, 0);
      queue_op(CMD_WRITE, -1, 0, 0, 0, 'hBEEF, 0);
      queue_op(CMD_READ, 0, 256, 0, 0, 0, 0);
      queue_op(CMD_WRITE, -32768, 32767, 0, 0, 'h5555, 0);
      queue_op(CMD_READ, 32767, -32768, 0, 0, 0, 0);
      queue_op(CMD_DRAW, 0, 0, 4, 4, 'hFFFF, 0);
      queue_op(CMD_DRAW, 2, 2, 4, 4, 'hF81F, 254);
      queue_op(CMD_READ, 0, 0, 0, 0, 0, 0);
      queue_op(CMD_READ, 3, 3, 0, 0, 0, 0);
      queue_op(CMD_DRAW, -5, -5, 10, 10, 'h07E0, 128);
      queue_op(CMD_DRAW, 10, 10, 0, 5, 'hFFFF, ALPHA_OPAQUE);
      queue_op(CMD_DRAW, 10, 10, 5, 0, 'hFFFF, ALPHA_OPAQUE);
      queue_op(CMD_DRAW, 256, 0, 10, 10, 'hFFFF, ALPHA_OPAQUE);
      queue_op(CMD_DRAW, -10, 0, 10, 10, 'hFFFF, ALPHA_OPAQUE);
      queue_op(CMD_DRAW, 0, -32768, 1, 65535, 'hAAAA, ALPHA_OPAQUE);
      queue_op(CMD_DRAW, 32767, 32767, 65535, 65535, 'h0F0F, 17);
      queue_op(CMD_DRAW, 250, 250, 65535, 65535, 'h5A5A, 77);
      queue_op(CMD_UNUSED, 12, 34, 56, 78, 'hC3C3, 200);
      queue_op(CMD_READ, 5, 5, 0, 0, 0, 0);
      queue_op(CMD_READ, 253, 253, 0, 0, 0, 0);
      queue_random_ops(150);

      queue_csr(CSR_BYTE_SWAPPED, 1);
      queue_random_ops(120);

      queue_csr(CSR_TARGET_WIDTH, 1);
      queue_csr(CSR_TARGET_HEIGHT, 1);
      queue_csr(CSR_BYTE_SWAPPED, 0);
      queue_random_ops(40);

      queue_csr(CSR_TARGET_WIDTH, 0);
      queue_csr(CSR_TARGET_HEIGHT, 0);
      queue_random_ops(20);

      queue_csr(CSR_TARGET_WIDTH, 300);
      queue_csr(CSR_TARGET_HEIGHT, 511);
      queue_csr(CSR_BYTE_SWAPPED, 1);
      queue_random_ops(80);

      repeat (3) begin
         queue_csr(CSR_TARGET_WIDTH, $urandom_range(1, 256));
         queue_csr(CSR_TARGET_HEIGHT, $urandom_range(1, 256));
         queue_csr(CSR_BYTE_SWAPPED, $urandom_range(0, 1));
         queue_random_ops(55);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (cmd_queue.size() != 0 || start || busy || pending_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("rgb565_rect_fill_blend_core_tb: clean");
      else
         $display("rgb565_rect_fill_blend_core_tb: errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/rgbf_pkg.sv
rtl/rgbf_ctrl.sv
rtl/rgbf_datapath.sv
rtl/rgb565_rect_fill_blend_core.sv
test/rgb565_rect_fill_blend_core_tb.sv
